/* hdl/etx_neighbor_probe_table_macros.svh */
// Assertion macros for the ETX neighbor probe table checker.
`ifndef ETX_NEIGHBOR_PROBE_TABLE_MACROS_SVH
`define ETX_NEIGHBOR_PROBE_TABLE_MACROS_SVH

// Assert that an antecedent implies a consequent on the same edge.
`define ENPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert that an antecedent implies a consequent on the next edge.
`define ENPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/enpt_pkg.sv */
// Package: shared constants and types of the ETX neighbor probe table.
`timescale 1ns / 1ps
`default_nettype none
package enpt_pkg;
    localparam int TABLE_DEPTH_DEF  = 32;
    localparam int WINDOW_SLOTS_DEF = 12;
    localparam logic [31:0] ETX_INFINITE = 32'hFFFF_FFFF;
    localparam logic [21:0] ETX_SCALE2   = 22'd2000000;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_TICK   = 2'd1,
        OP_READ   = 2'd2,
        OP_DUMP   = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] neighbor_addr;
        logic [3:0]  probe_slot;
        logic [7:0]  reverse_count;
    } t_cmd;

    typedef struct packed {
        logic        ok;
        logic [31:0] entry_addr;
        logic [3:0]  probe_count;
        logic [31:0] etx_value;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_EMIT,
        ST_TICK
    } t_state;
endpackage
`default_nettype wire

/* hdl/enpt_if.sv */
// Interfaces: valid/ready channels for commands and results.
`timescale 1ns / 1ps
`default_nettype none
interface enpt_cmd_if;
    logic valid;
    logic ready;
    enpt_pkg::t_opcode opcode;
    logic [31:0] neighbor_addr;
    logic [3:0]  probe_slot;
    logic [7:0]  reverse_count;
    modport source (output valid, opcode, neighbor_addr, probe_slot, reverse_count,
                    input ready);
    modport sink (input valid, opcode, neighbor_addr, probe_slot, reverse_count,
                  output ready);
endinterface

interface enpt_res_if;
    logic valid;
    logic ready;
    logic        ok;
    logic [31:0] entry_addr;
    logic [3:0]  probe_count;
    logic [31:0] etx_value;
    logic        last;
    modport source (output valid, ok, entry_addr, probe_count, etx_value, last,
                    input ready);
    modport sink (input valid, ok, entry_addr, probe_count, etx_value, last,
                  output ready);
endinterface
`default_nettype wire

/* hdl/enpt_front.sv */
// Front: accept commands and queue them in a short FIFO for the engine.
`timescale 1ns / 1ps
`default_nettype none
module enpt_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    enpt_cmd_if.sink             cmd,
    output enpt_pkg::t_cmd       o_cmd,
    output logic                 o_cmd_valid,
    input  wire logic            i_cmd_take
);
    import enpt_pkg::*;

    t_cmd       r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    logic       w_push, w_pop;
    t_cmd       w_in;

    assign cmd.ready   = (r_cnt != 2'd2);
    assign w_push      = cmd.valid && cmd.ready;
    assign w_pop       = i_cmd_take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_in = '{opcode: cmd.opcode, neighbor_addr: cmd.neighbor_addr,
                    probe_slot: cmd.probe_slot, reverse_count: cmd.reverse_count};

    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
        end
        if (w_push) r_q[r_wr] <= w_in;
    end
endmodule
`default_nettype wire

/* hdl/enpt_div.sv */
// Divider: restoring 22-bit by 22-bit division, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module enpt_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [21:0] i_num,
    input  wire logic [21:0] i_den,
    output logic             o_done,
    output logic [21:0]      o_quot
);
    logic [21:0] r_num, r_den, r_quot;
    logic [22:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [22:0] w_sh;
    logic [22:0] w_sub;

    assign w_sh   = {r_rem[21:0], r_num[21]};
    assign w_sub  = w_sh - {1'b0, r_den};
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd22;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[20:0], 1'b0};
            if (!w_sub[22]) begin
                r_rem  <= w_sub;
                r_quot <= {r_quot[20:0], 1'b1};
            end else begin
                r_rem  <= w_sh;
                r_quot <= {r_quot[20:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/enpt_engine.sv */
// Engine: table storage, per-command sequencing and result register.
`timescale 1ns / 1ps
`default_nettype none
module enpt_engine #(
    parameter int TABLE_DEPTH  = enpt_pkg::TABLE_DEPTH_DEF,
    parameter int WINDOW_SLOTS = enpt_pkg::WINDOW_SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire enpt_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_take,
    enpt_res_if.source          res
);
    import enpt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = $clog2(WINDOW_SLOTS);
    localparam logic [IW:0] LASTI = (IW + 1)'(TABLE_DEPTH - 1);
    localparam logic [SW-1:0] LASTS = SW'(WINDOW_SLOTS - 1);

    logic [TABLE_DEPTH-1:0]  r_valid;
    logic [31:0]             r_key [TABLE_DEPTH];
    logic [WINDOW_SLOTS-1:0] r_map [TABLE_DEPTH];
    logic [7:0]              r_rev [TABLE_DEPTH];
    logic [SW-1:0]           r_wp;

    t_state      r_st, n_st;
    t_cmd        r_cmd;
    logic [IW:0] r_idx;
    logic        r_found, r_free_ok, r_any;
    logic [IW-1:0] r_hit, r_free;
    logic [31:0] r_addr;
    logic [3:0]  r_cnt;
    logic        r_ok, r_lst, r_dump;
    logic [15:0] r_prod;
    logic        r_ov;
    t_result     r_res;

    logic [IW-1:0]           w_i;
    logic [WINDOW_SLOTS-1:0] w_map, w_new, w_bit, w_keep;
    logic [SW-1:0]           w_old, w_np, w_nold;
    logic [3:0]              w_c;
    logic                    w_div_start, w_div_done;
    logic [21:0]             w_quot;
    logic [21:0]             w_den;
    logic [TABLE_DEPTH-1:0]  w_live;
    logic                    w_later;
    logic                    w_row;

    assign w_i = r_idx[IW-1:0];
    assign w_old  = (r_wp == LASTS) ? '0 : r_wp + SW'(1);
    assign w_np   = w_old;
    assign w_nold = (w_np == LASTS) ? '0 : w_np + SW'(1);
    assign w_den  = {5'd0, r_prod, 1'b0};

    // Probe count of a map, leaving out the current and oldest slots.
    function automatic logic [3:0] f_count(input logic [WINDOW_SLOTS-1:0] m,
                                           input logic [SW-1:0] c,
                                           input logic [SW-1:0] o);
        logic [3:0] s;
        s = '0;
        for (int j = 0; j < WINDOW_SLOTS; j++)
            if (SW'(j) != c && SW'(j) != o) s = s + 4'(m[j]);
        return s;
    endfunction

    always_comb begin
        w_bit = '0;
        for (int j = 0; j < WINDOW_SLOTS; j++)
            if (r_cmd.probe_slot == 4'(j)) w_bit[j] = 1'b1;
    end

    // Entries that a dump reports, and whether one follows the current index.
    always_comb begin
        w_keep = '1;
        for (int j = 0; j < WINDOW_SLOTS; j++)
            if (SW'(j) == r_wp || SW'(j) == w_old) w_keep[j] = 1'b0;
        w_later = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_live[k] = r_valid[k] && ((r_map[k] & w_keep) != '0);
            if (IW'(k) > w_i) w_later = w_later | w_live[k];
        end
    end

    assign w_map = r_found ? (r_map[r_hit] | w_bit) : w_bit;
    assign w_new = r_map[w_i];
    assign w_c   = f_count(w_new, r_wp, w_old);
    assign w_row = w_live[w_i];

    enpt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (ETX_SCALE2 + {6'd0, r_prod}),
        .i_den  (w_den),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign res.valid       = (r_st == ST_EMIT);
    assign res.ok          = r_res.ok;
    assign res.entry_addr  = r_res.entry_addr;
    assign res.probe_count = r_res.probe_count;
    assign res.etx_value   = r_res.etx_value;
    assign res.last        = r_res.last;
    assign o_cmd_take      = (r_st == ST_IDLE) && i_cmd_valid;

    // Sub-state flags: r_ov marks the product phase before the divider starts.
    assign w_div_start = (r_st == ST_DIV) && r_ov;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (i_cmd_valid) n_st = (i_cmd.opcode == OP_TICK) ? ST_TICK : ST_SCAN;
            end
            ST_SCAN: begin
                if (r_dump) begin
                    if (r_idx > LASTI) n_st = r_any ? ST_IDLE : ST_EMIT;
                    else if (w_row) n_st = ST_DIV;
                end else if (r_idx > LASTI) begin
                    n_st = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!r_ov && (r_prod == 16'd0 || w_div_done)) n_st = ST_EMIT;
            end
            ST_EMIT: begin
                if (res.ready) n_st = (r_dump && !r_res.last) ? ST_SCAN : ST_IDLE;
            end
            ST_TICK: n_st = ST_EMIT;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_valid <= '0;
            r_wp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd     <= i_cmd;
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_any     <= 1'b0;
                        r_dump    <= (i_cmd.opcode == OP_DUMP);
                    end
                end
                ST_TICK: begin
                    // Advance the pointer and clear the new oldest slot everywhere.
                    r_wp <= w_np;
                    for (int k = 0; k < TABLE_DEPTH; k++)
                        r_map[k][w_nold] <= 1'b0;
                    r_res <= '{ok: 1'b1, entry_addr: '0, probe_count: '0,
                               etx_value: '0, last: 1'b1};
                end
                ST_SCAN: begin
                    if (r_dump) begin
                        if (r_idx > LASTI) begin
                            r_res <= '{ok: 1'b0, entry_addr: '0, probe_count: '0,
                                       etx_value: ETX_INFINITE, last: 1'b1};
                            r_dump <= 1'b0;
                        end else begin
                            if (w_row) begin
                                // Last row when no later entry has probes to report.
                                r_any  <= 1'b1;
                                r_ok   <= 1'b1;
                                r_addr <= r_key[w_i];
                                r_cnt  <= w_c;
                                r_prod <= 16'(w_c) * 16'(r_rev[w_i]);
                                r_lst  <= !w_later;
                                r_ov   <= 1'b1;
                            end
                            r_idx <= r_idx + 1'b1;
                        end
                    end else if (r_idx <= LASTI) begin
                        if (r_valid[w_i] && r_key[w_i] == r_cmd.neighbor_addr && !r_found) begin
                            r_found <= 1'b1;
                            r_hit   <= w_i;
                        end
                        if (!r_valid[w_i] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= w_i;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else if (r_cmd.opcode == OP_READ) begin
                        r_addr <= r_cmd.neighbor_addr;
                        r_lst  <= 1'b1;
                        if (r_found) begin
                            r_ok   <= 1'b1;
                            r_cnt  <= f_count(r_map[r_hit], r_wp, w_old);
                            r_prod <= 16'(f_count(r_map[r_hit], r_wp, w_old)) *
                                      16'(r_rev[r_hit]);
                        end else begin
                            r_ok <= 1'b0;
                            r_cnt <= '0;
                            r_prod <= '0;
                        end
                        r_ov <= 1'b1;
                    end else begin
                        // Update: store into the hit or the first free entry.
                        r_addr <= r_cmd.neighbor_addr;
                        r_lst  <= 1'b1;
                        if (r_found || r_free_ok) begin
                            r_valid[r_found ? r_hit : r_free] <= 1'b1;
                            r_key[r_found ? r_hit : r_free]   <= r_cmd.neighbor_addr;
                            r_map[r_found ? r_hit : r_free]   <= w_map;
                            r_rev[r_found ? r_hit : r_free]   <= r_cmd.reverse_count;
                            r_ok   <= 1'b1;
                            r_cnt  <= f_count(w_map, r_wp, w_old);
                            r_prod <= 16'(f_count(w_map, r_wp, w_old)) *
                                      16'(r_cmd.reverse_count);
                        end else begin
                            r_ok <= 1'b0;
                            r_cnt <= '0;
                            r_prod <= '0;
                        end
                        r_ov <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (!r_ov && (r_prod == 16'd0 || w_div_done)) begin
                        r_res <= '{ok: r_ok, entry_addr: r_addr, probe_count: r_cnt,
                                   etx_value: (r_prod == 16'd0) ? ETX_INFINITE
                                                                : {10'd0, w_quot},
                                   last: r_lst};
                    end
                end
                ST_EMIT: begin
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/etx_neighbor_probe_table.sv */
// Top level: ETX neighbor probe table with decoupled command queue and engine.
// Update/read: queue, linear key scan, then a 22-bit restoring divide.
// Tick: advance the window, then emit. Dump: scan every entry, with a divide per reported row.
// The engine runs one command at a time; a 2-deep queue keeps accepting while it has room.
// Reset (synchronous, active low) clears valid bits, window pointer and control.
`timescale 1ns / 1ps
`default_nettype none
module etx_neighbor_probe_table #(
    parameter int TABLE_DEPTH  = enpt_pkg::TABLE_DEPTH_DEF,
    parameter int WINDOW_SLOTS = enpt_pkg::WINDOW_SLOTS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    enpt_cmd_if.sink   i_cmd,
    enpt_res_if.source o_res
);
    import enpt_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_take;

    // Queue commands so the producer stalls independently of the engine.
    enpt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .cmd        (i_cmd),
        .o_cmd      (w_cmd),
        .o_cmd_valid(w_cmd_valid),
        .i_cmd_take (w_cmd_take)
    );

    // Execute commands: scan the table, update, divide and emit transactions.
    enpt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cmd_valid(w_cmd_valid),
        .o_cmd_take (w_cmd_take),
        .res        (o_res)
    );
endmodule
`default_nettype wire

/* hdl/enpt_checker.sv */
// Checker: port-level properties of the probe table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "etx_neighbor_probe_table_macros.svh"
module enpt_props (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        res_ok,
    input wire logic [3:0]  res_cnt,
    input wire logic [31:0] res_etx,
    input wire logic        res_last
);
    `ENPT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, res_valid && !res_ready, res_valid)
    `ENPT_ASSERT_IMPL(a_miss_inf, i_clk, i_rst_n, res_valid && !res_ok, res_etx == 32'hFFFF_FFFF)
    `ENPT_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, res_valid, res_cnt <= 4'd14)
    `ENPT_ASSERT_IMPL(a_miss_last, i_clk, i_rst_n, res_valid && !res_ok, res_last)
endmodule

bind etx_neighbor_probe_table enpt_props u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .res_valid(o_res.valid),
    .res_ready(o_res.ready),
    .res_ok   (o_res.ok),
    .res_cnt  (o_res.probe_count),
    .res_etx  (o_res.etx_value),
    .res_last (o_res.last)
);
`default_nettype wire

/* verif/enpt_checker.sv */
// Checker: watches both channels, predicts table results and compares them.
`timescale 1ns / 1ps
`default_nettype none
module enpt_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    enpt_cmd_if       i_cmd,
    enpt_res_if       i_res,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_result_count
);
    import enpt_pkg::*;

    localparam int DEPTH = 32;
    localparam int SLOTS = 12;

    logic [3:0]  win_ptr;
    logic        tbl_valid [DEPTH];
    logic [31:0] tbl_key [DEPTH];
    logic [11:0] tbl_map [DEPTH];
    logic [7:0]  tbl_rev [DEPTH];
    t_result     expected_results [$];

    function automatic logic [3:0] slot_after(input logic [3:0] s);
        return (s >= SLOTS - 1) ? 4'd0 : s + 4'd1;
    endfunction

    function automatic logic [3:0] heard_count(input logic [11:0] map);
        logic [3:0] c;
        logic [3:0] oldest;
        c = 0;
        oldest = slot_after(win_ptr);
        for (int j = 0; j < SLOTS; j++)
            if (j != win_ptr && j != oldest && map[j]) c++;
        return c;
    endfunction

    function automatic logic [31:0] etx_metric(input logic [3:0] c, input logic [7:0] r);
        logic [31:0] d;
        if (c == 0 || r == 0) return ETX_INFINITE;
        d = c * r;
        return (32'd2000000 + d) / (2 * d);
    endfunction

    function automatic t_result mk(input logic ok, input logic [31:0] a,
                                   input logic [3:0] c, input logic [31:0] e,
                                   input logic l);
        t_result r;
        r.ok = ok; r.entry_addr = a; r.probe_count = c; r.etx_value = e; r.last = l;
        return r;
    endfunction

    function automatic int lookup(input logic [31:0] a);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_key[i] == a) return i;
        return -1;
    endfunction

    task automatic predict_command(input t_opcode op, input logic [31:0] a,
                                   input logic [3:0] s, input logic [7:0] r);
        int idx;
        int n;
        logic [11:0] bit_set;
        logic [3:0] c;
        bit_set = (s < SLOTS) ? (12'd1 << s) : 12'd0;
        case (op)
            OP_UPDATE: begin
                idx = lookup(a);
                if (idx < 0) begin
                    for (idx = 0; idx < DEPTH; idx++)
                        if (!tbl_valid[idx]) break;
                    if (idx >= DEPTH) begin
                        expected_results.push_back(mk(1'b0, a, 0, ETX_INFINITE, 1'b1));
                        return;
                    end
                    tbl_valid[idx] = 1'b1;
                    tbl_key[idx] = a;
                    tbl_map[idx] = bit_set;
                end else begin
                    tbl_map[idx] |= bit_set;
                end
                tbl_rev[idx] = r;
                c = heard_count(tbl_map[idx]);
                expected_results.push_back(mk(1'b1, a, c, etx_metric(c, r), 1'b1));
            end
            OP_TICK: begin
                win_ptr = slot_after(win_ptr);
                for (int i = 0; i < DEPTH; i++)
                    tbl_map[i][slot_after(win_ptr)] = 1'b0;
                expected_results.push_back(mk(1'b1, 0, 0, 0, 1'b1));
            end
            OP_READ: begin
                idx = lookup(a);
                if (idx < 0) begin
                    expected_results.push_back(mk(1'b0, a, 0, ETX_INFINITE, 1'b1));
                end else begin
                    c = heard_count(tbl_map[idx]);
                    expected_results.push_back(
                        mk(1'b1, a, c, etx_metric(c, tbl_rev[idx]), 1'b1));
                end
            end
            default: begin
                n = 0;
                for (int i = 0; i < DEPTH; i++) begin
                    if (!tbl_valid[i]) continue;
                    c = heard_count(tbl_map[i]);
                    if (c == 0) continue;
                    expected_results.push_back(
                        mk(1'b1, tbl_key[i], c, etx_metric(c, tbl_rev[i]), 1'b0));
                    n++;
                end
                if (n == 0) expected_results.push_back(mk(1'b0, 0, 0, ETX_INFINITE, 1'b1));
                else expected_results[$].last = 1'b1;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            win_ptr = 0;
            for (int i = 0; i < DEPTH; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_map[i] = 0;
            end
            expected_results.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            // Compare the result first: it was caused by earlier commands only.
            if (i_res.valid && i_res.ready) begin
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: addr %h", i_res.entry_addr);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.ok !== want.ok ||
                        i_res.entry_addr !== want.entry_addr ||
                        i_res.probe_count !== want.probe_count ||
                        i_res.etx_value !== want.etx_value ||
                        i_res.last !== want.last) begin
                        if (i_res.ok !== want.ok)
                            $error("ok: expected %0d got %0d", want.ok, i_res.ok);
                        if (i_res.entry_addr !== want.entry_addr)
                            $error("entry_addr: expected %h got %h",
                                   want.entry_addr, i_res.entry_addr);
                        if (i_res.probe_count !== want.probe_count)
                            $error("probe_count: expected %0d got %0d",
                                   want.probe_count, i_res.probe_count);
                        if (i_res.etx_value !== want.etx_value)
                            $error("etx_value: expected %0d got %0d",
                                   want.etx_value, i_res.etx_value);
                        if (i_res.last !== want.last)
                            $error("last: expected %0d got %0d", want.last, i_res.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                predict_command(i_cmd.opcode, i_cmd.neighbor_addr,
                                i_cmd.probe_slot, i_cmd.reverse_count);
        end
    end

    assign o_pending = expected_results.size();
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Testbench top: drives table commands, stalls results, reports the verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import enpt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   result_count;
    int   updates_sent;
    int   ticks_sent;
    int   reads_sent;
    int   dumps_sent;

    enpt_cmd_if cmd ();
    enpt_res_if res ();

    etx_neighbor_probe_table dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd.sink),
        .o_res  (res.source)
    );

    enpt_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_res         (res),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stall the receiver on a pattern of its own: calm stretches, then random holds.
    initial begin
        int phase;
        res.ready = 1'b0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase = (phase + 1) % 600;
            if (phase < 150) res.ready <= 1'b1;
            else res.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Small address pool so updates and reads hit existing entries often.
    logic [31:0] addr_pool [8];

    // Hold one transaction until the block takes it; valid stays high
    // afterwards, until idle_gap or drain drops it.
    task automatic send(input t_opcode op, input logic [31:0] a,
                        input logic [3:0] s, input logic [7:0] r);
        cmd.valid         <= 1'b1;
        cmd.opcode        <= op;
        cmd.neighbor_addr <= a;
        cmd.probe_slot    <= s;
        cmd.reverse_count <= r;
        do @(posedge i_clk); while (!cmd.ready);
        case (op)
            OP_UPDATE: updates_sent++;
            OP_TICK:   ticks_sent++;
            OP_READ:   reads_sent++;
            default:   dumps_sent++;
        endcase
    endtask

    task automatic idle_gap();
        int gap;
        cmd.valid <= 1'b0;
        gap = $urandom_range(0, 4) == 0 ? $urandom_range(1, 60) : 0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int burst;
        int pick;
        logic [31:0] a;
        updates_sent = 0; ticks_sent = 0; reads_sent = 0; dumps_sent = 0;
        cmd.valid = 1'b0;
        cmd.opcode = OP_UPDATE;
        cmd.neighbor_addr = 0;
        cmd.probe_slot = 0;
        cmd.reverse_count = 0;
        i_rst_n = 1'b0;
        for (int i = 0; i < 8; i++) addr_pool[i] = $urandom();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dump, missing read, field extremes, bad slot, zero reverse.
        send(OP_DUMP, 0, 0, 0);
        send(OP_READ, 32'hFFFF_FFFF, 0, 0);
        send(OP_UPDATE, 32'h0000_0000, 4'd2, 8'd0);
        send(OP_UPDATE, 32'hFFFF_FFFF, 4'd11, 8'd255);
        send(OP_UPDATE, 32'hFFFF_FFFF, 4'd15, 8'd1);
        send(OP_UPDATE, 32'hFFFF_FFFF, 4'd5, 8'd255);
        send(OP_UPDATE, 32'h0000_0000, 4'd0, 8'd1);
        send(OP_UPDATE, 32'h0000_0000, 4'd1, 8'd1);
        send(OP_READ, 32'h0000_0000, 0, 0);
        send(OP_READ, 32'hFFFF_FFFF, 0, 0);
        send(OP_DUMP, 0, 0, 0);
        for (int t = 0; t < 13; t++) send(OP_TICK, 0, 0, 0);
        send(OP_READ, 32'hFFFF_FFFF, 0, 0);
        drain();

        // Random phase: mostly updates and reads on the pool, some ticks and dumps.
        while (updates_sent + ticks_sent + reads_sent + dumps_sent < 80) begin
            burst = $urandom_range(1, 10);
            repeat (burst) begin
                pick = $urandom_range(0, 19);
                a = ($urandom_range(0, 5) == 0) ? $urandom() : addr_pool[$urandom_range(0, 7)];
                if (pick < 9)
                    send(OP_UPDATE, a, 4'($urandom_range(0, 15)), 8'($urandom()));
                else if (pick < 14)
                    send(OP_READ, a, 4'($urandom()), 8'($urandom()));
                else if (pick < 18)
                    send(OP_TICK, $urandom(), 4'($urandom()), 8'($urandom()));
                else
                    send(OP_DUMP, $urandom(), 4'($urandom()), 8'($urandom()));
            end
            idle_gap();
            if ($urandom_range(0, 15) == 0) drain();
        end

        // Fill the table with fresh keys, then overflow it.
        for (int i = 0; i < 34; i++)
            send(OP_UPDATE, $urandom(), 4'($urandom_range(0, 11)),
                 8'($urandom_range(1, 255)));
        send(OP_DUMP, 0, 0, 0);
        send(OP_READ, addr_pool[1], 0, 0);
        drain();

        repeat (200) @(posedge i_clk);
        $display("covered %0d updates, %0d ticks, %0d reads, %0d dumps; %0d results checked",
                 updates_sent, ticks_sent, reads_sent, dumps_sent, result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #1500000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
